// File: rtl/assert_macros.svh
// Assertion macros for the RTL files; fiqd_dpath includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge while reset is released.
`define CHK_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that one condition implies another condition in the next cycle.
`define CHK_NEXT(label, clk, rst_n, cond, res, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) else $error(msg);

`endif

// File: rtl/fiqd_pkg.sv
package fiqd_pkg;

  localparam int unsigned ArrW   = 60;
  localparam int unsigned SvcW   = 32;
  localparam int unsigned TimeW  = 64;
  localparam int unsigned DelayW = 60;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic fit;
    logic pick;
    logic calc;
    logic update;
  } cmd_t;

endpackage

// File: rtl/free_interval_queue_delay.sv
// Channel   Ports                                               Direction
// in        in_valid/in_ready, in_arrival_time, in_service_time  request in
// out       out_valid/out_ready, out_delay                       result out
// cfg       cfg_valid/cfg_ready, cfg_data (min_gap)              register write
//
// Each request takes the sequencer through its steps in order: accept, fit
// test in every cell, first-fit pick, piece cut, and the shift of the cell
// row; the result is registered with that shift.
// Synchronous active-low reset leaves one interval from 0 to all ones.
// A new request is taken while the previous result waits in the output
// register; the row update stalls only while it is full and out_ready is low.
module free_interval_queue_delay #(
  parameter int unsigned MAX_GAPS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [fiqd_pkg::ArrW-1:0]   in_arrival_time,
  input  logic [fiqd_pkg::SvcW-1:0]   in_service_time,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [fiqd_pkg::DelayW-1:0] out_delay,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [fiqd_pkg::SvcW-1:0]   cfg_data
);

  fiqd_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  fiqd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  fiqd_dpath #(
    .MAX_GAPS (MAX_GAPS)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .arrival_time (in_arrival_time),
    .service_time (in_service_time),
    .cfg_we       (cfg_valid),
    .cfg_data     (cfg_data),
    .wait_out     (out_delay)
  );

endmodule

// File: rtl/fiqd_ctrl.sv
module fiqd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output fiqd_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_FIT    = 5'b00010,
    ST_PICK   = 5'b00100,
    ST_CALC   = 5'b01000,
    ST_UPDATE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // Sequencer for one request at a time.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_FIT;
        end
      end
      ST_FIT: begin
        cmd.fit   = 1'b1;
        state_nxt = ST_PICK;
      end
      ST_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = ST_CALC;
      end
      ST_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (out_free) begin
          cmd.update    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/fiqd_dpath.sv
`include "assert_macros.svh"

module fiqd_dpath #(
  parameter int unsigned MAX_GAPS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fiqd_pkg::cmd_t                cmd,
  input  logic [fiqd_pkg::ArrW-1:0]     arrival_time,
  input  logic [fiqd_pkg::SvcW-1:0]     service_time,
  input  logic                          cfg_we,
  input  logic [fiqd_pkg::SvcW-1:0]     cfg_data,
  output logic [fiqd_pkg::DelayW-1:0]   wait_out
);

  localparam int unsigned TW = fiqd_pkg::TimeW;
  localparam int unsigned CW = $clog2(MAX_GAPS + 2);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_GAPS);

  // Cell row holding the free intervals, oldest first.
  logic [TW-1:0] s_r [MAX_GAPS];
  logic [TW-1:0] e_r [MAX_GAPS];
  logic [CW-1:0] count_r;
  logic [fiqd_pkg::SvcW-1:0] min_gap_r;

  logic [fiqd_pkg::ArrW-1:0] arr_r;
  logic [fiqd_pkg::SvcW-1:0] svc_r;
  logic [fiqd_pkg::ArrW:0]   fin_r;

  logic [MAX_GAPS-1:0] fit_r, k2_r, hot_r, before_r;
  logic                any_r, kind2_r;
  logic [TW-1:0]       hs_r, he_r;

  logic [TW-1:0]       p0s_r, p0e_r, p1s_r, p1e_r;
  logic [1:0]          np_r;
  logic [fiqd_pkg::DelayW-1:0] delay_r, qd_r;

  logic [TW-1:0] arr_x, svc_x, fin_x;
  assign arr_x = TW'(arr_r);
  assign svc_x = TW'(svc_r);
  assign fin_x = TW'(fin_r);

  // Per-cell fit tests, all cells in parallel.
  logic [MAX_GAPS-1:0] fit_c, k2_c;
  always_comb begin
    for (int i = 0; i < MAX_GAPS; i++) begin
      logic vld, f1, f2;
      vld = (CW'(i) < count_r);
      f1  = (arr_x >= s_r[i]) && (fin_x <= e_r[i]);
      f2  = (arr_x < s_r[i]) && (e_r[i] >= s_r[i]) && ((e_r[i] - s_r[i]) >= svc_x);
      fit_c[i] = vld && (f1 || f2);
      k2_c[i]  = vld && !f1 && f2;
    end
  end

  // Priority pick of the first fitting cell.
  logic [MAX_GAPS-1:0] oh_c;
  logic [TW-1:0]       hs_c, he_c;
  assign oh_c = fit_r & (~fit_r + MAX_GAPS'(1));
  always_comb begin
    hs_c = '0;
    he_c = '0;
    for (int i = 0; i < MAX_GAPS; i++) begin
      hs_c = hs_c | (s_r[i] & {TW{oh_c[i]}});
      he_c = he_c | (e_r[i] & {TW{oh_c[i]}});
    end
  end

  // Pieces that survive the cut and the delay.
  logic [TW-1:0] mg_x, ns_c, wait_c;
  logic          keep_a, keep_b, keep_n;
  assign mg_x   = TW'(min_gap_r);
  assign ns_c   = hs_r + svc_x;
  assign wait_c = hs_r - arr_x;
  assign keep_a = (arr_x - hs_r) >= mg_x;
  assign keep_b = (he_r - fin_x) >= mg_x;
  assign keep_n = (he_r - ns_c) >= mg_x;

  // Count after the update and the overflow drop.
  logic [CW-1:0] newcnt_c;
  logic          drop_c;
  assign newcnt_c = count_r + CW'(np_r) - CW'(1);
  assign drop_c   = newcnt_c > MaxCnt;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      arr_r <= arrival_time;
      svc_r <= service_time;
      fin_r <= (fiqd_pkg::ArrW+1)'(arrival_time) + (fiqd_pkg::ArrW+1)'(service_time);
    end
    if (cmd.fit) begin
      fit_r <= fit_c;
      k2_r  <= k2_c;
    end
    if (cmd.pick) begin
      hot_r    <= oh_c;
      before_r <= oh_c - MAX_GAPS'(1);
      any_r    <= |fit_r;
      kind2_r  <= |(oh_c & k2_r);
      hs_r     <= hs_c;
      he_r     <= he_c;
    end
    if (cmd.calc) begin
      if (!any_r) begin
        np_r    <= 2'd1;
        delay_r <= '0;
      end else if (kind2_r) begin
        p0s_r   <= ns_c;
        p0e_r   <= he_r;
        np_r    <= {1'b0, keep_n};
        delay_r <= (wait_c[TW-1:fiqd_pkg::DelayW] != '0) ? '1 :
                   wait_c[fiqd_pkg::DelayW-1:0];
      end else begin
        p0s_r   <= keep_a ? hs_r  : fin_x;
        p0e_r   <= keep_a ? arr_x : he_r;
        p1s_r   <= fin_x;
        p1e_r   <= he_r;
        np_r    <= 2'(keep_a) + 2'(keep_b);
        delay_r <= '0;
      end
    end
    if (cmd.update) begin
      qd_r <= delay_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_gap_r <= fiqd_pkg::SvcW'(1);
    end else if (cfg_we) begin
      min_gap_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CW'(1);
    end else if (cmd.update && any_r) begin
      count_r <= newcnt_c - CW'(drop_c);
    end
  end

  // Each cell picks its new interval from itself, its neighbors or a piece.
  for (genvar i = 0; i < MAX_GAPS; i++) begin : g_cell
    localparam int unsigned Nx = (i + 1 < MAX_GAPS) ? i + 1 : i;
    localparam int unsigned Pv = (i > 0) ? i - 1 : 0;
    logic          b, h0, h1;
    logic [TW-1:0] ns, ne, srs, sre;

    always_comb begin
      if (drop_c) begin
        b   = (i + 1 < MAX_GAPS) ? before_r[Nx] : 1'b0;
        h0  = (i + 1 < MAX_GAPS) ? hot_r[Nx] : 1'b0;
        h1  = hot_r[i];
        srs = s_r[i];
        sre = e_r[i];
      end else begin
        b  = before_r[i];
        h0 = hot_r[i];
        h1 = (i > 0) ? hot_r[Pv] : 1'b0;
        case (np_r)
          2'd0: begin
            srs = (i + 1 < MAX_GAPS) ? s_r[Nx] : '0;
            sre = (i + 1 < MAX_GAPS) ? e_r[Nx] : '0;
          end
          2'd1: begin
            srs = s_r[i];
            sre = e_r[i];
          end
          default: begin
            srs = (i > 0) ? s_r[Pv] : '0;
            sre = (i > 0) ? e_r[Pv] : '0;
          end
        endcase
      end
      if (b) begin
        ns = drop_c ? s_r[Nx] : s_r[i];
        ne = drop_c ? e_r[Nx] : e_r[i];
      end else if (h0 && np_r != 2'd0) begin
        ns = p0s_r;
        ne = p0e_r;
      end else if (h1 && np_r == 2'd2) begin
        ns = p1s_r;
        ne = p1e_r;
      end else begin
        ns = srs;
        ne = sre;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        s_r[i] <= '0;
        e_r[i] <= (i == 0) ? '1 : '0;
      end else if (cmd.update && any_r) begin
        s_r[i] <= ns;
        e_r[i] <= ne;
      end
    end
  end

  assign wait_out = qd_r;

  `CHK_PROP(a_count_range, clk, rst_n, (count_r != '0) && (count_r <= MaxCnt),
            "interval count out of range")
  `CHK_NEXT(a_hot_onehot, clk, rst_n, cmd.pick, $onehot0(hot_r),
            "first-fit pick is not one-hot")
  `CHK_NEXT(a_hot_fits, clk, rst_n, cmd.pick, (hot_r & ~fit_r) == '0,
            "picked cell did not fit")

endmodule
